// ===== design/c_subset_lexer_top_assert.svh =====
// Assertion helpers shared by the lexer modules.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef C_SUBSET_LEXER_TOP_ASSERT_SVH
`define C_SUBSET_LEXER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CSL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/csl_pkg.sv =====
package csl_pkg;

   localparam logic [7:0] MAX_LEXEME = 8'd255;

   localparam int NUM_KW      = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [8:0] ALL_KW = 9'h1FF;

   localparam logic [7:0] CH_NL         = 8'h0A;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_VT         = 8'h0B;
   localparam logic [7:0] CH_FF         = 8'h0C;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // keyword spellings, zero padded to eight bytes
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [7:0] KW_LEN [NUM_KW] = '{
      8'd3, 8'd5, 8'd4, 8'd2, 8'd4, 8'd5, 8'd3, 8'd6, 8'd2
   };

   typedef enum logic [2:0] {
      KIND_KEYWORD = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_CONST   = 3'd2,
      KIND_SYMBOL  = 3'd3,
      KIND_END     = 3'd4,
      KIND_EMPTY   = 3'd5,
      KIND_COMMENT = 3'd6
   } token_kind_type;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_SLASH   = 5'b00010,
      MODE_IDENT   = 5'b00100,
      MODE_CONST   = 5'b01000,
      MODE_COMMENT = 5'b10000
   } scan_mode_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    line;
      logic [7:0]     len;
      logic [3:0]     kwi;
      logic [7:0]     sym;
   } token_type;

   // one queue entry holds every token that one input word produced
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } queue_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } kw_match_type;

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_idchar(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
   endfunction

   // keep the keywords whose byte at pos equals c
   function automatic logic [8:0] kw_narrow(logic [8:0] mask, logic [7:0] pos,
                                            logic [7:0] c);
      logic [8:0] r;
      r = '0;
      for (int k = 0; k < NUM_KW; k++) begin
         if (mask[k] && (pos < KW_LEN[k]) && (KW_TEXT[k][pos[2:0]] == c)) begin
            r[k] = 1'b1;
         end
      end
      return r;
   endfunction

   // the highest-numbered surviving keyword of matching length wins
   function automatic kw_match_type kw_match(logic [8:0] mask, logic [7:0] len);
      kw_match_type m;
      m = '0;
      for (int k = 0; k < NUM_KW; k++) begin
         if (mask[k] && (KW_LEN[k] == len)) begin
            m.hit = 1'b1;
            m.idx = 4'(k);
         end
      end
      return m;
   endfunction

endpackage

// ===== design/csl_if.sv =====
interface csl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, in_byte, end_of_input, input ready);
   modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface csl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [15:0] line_number;
   logic [7:0]  lexeme_length;
   logic [3:0]  keyword_index;
   logic [7:0]  symbol_byte;
   logic        last;

   modport source (output valid, token_kind, line_number, lexeme_length,
                   keyword_index, symbol_byte, last, input ready);
   modport sink   (input valid, token_kind, line_number, lexeme_length,
                   keyword_index, symbol_byte, last, output ready);
endinterface

// ===== design/csl_front.sv =====
`include "c_subset_lexer_top_assert.svh"

module csl_front (
   input  logic                      clock,
   input  logic                      reset,
   csl_req_if.sink                   req,
   input  csl_pkg::queue_status_type qstat,
   output csl_pkg::queue_push_type   qpush
);

   csl_pkg::scan_mode_type mode_ff, mode_in;
   logic [15:0]            line_ff, line_in;
   logic [7:0]             len_ff, len_in;
   logic [8:0]             cands_ff, cands_in;
   logic [7:0]             first_ff, first_in;

   logic       accept;
   logic [7:0] c;
   logic [7:0] len_bump;

   // fresh-start lexing of the current byte
   csl_pkg::scan_mode_type fr_mode;
   logic [15:0]            fr_line;
   logic [7:0]             fr_len;
   logic [8:0]             fr_cands;
   logic [7:0]             fr_first;
   logic                   fr_emit;
   csl_pkg::token_type     fr_tok;

   csl_pkg::token_type     fl_tok, slash_tok, cmt_tok, end_tok, t0, t1;
   csl_pkg::kw_match_type  match;
   logic                   t0v, t1v;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;
   assign c         = req.in_byte;
   assign len_bump  = (len_ff < csl_pkg::MAX_LEXEME) ? len_ff + 8'd1 : len_ff;

   always_comb begin
      fr_mode  = csl_pkg::MODE_IDLE;
      fr_line  = line_ff;
      fr_len   = 8'd0;
      fr_cands = csl_pkg::ALL_KW;
      fr_first = first_ff;
      fr_emit  = 1'b0;
      fr_tok   = '0;
      if (c == csl_pkg::CH_NL) begin
         fr_line     = line_ff + 16'd1;
         fr_emit     = 1'b1;
         fr_tok.kind = csl_pkg::KIND_EMPTY;
         fr_tok.line = line_ff + 16'd1;
         fr_tok.len  = 8'd1;
         fr_tok.sym  = c;
      end else if (csl_pkg::is_blank(c)) begin
         fr_emit = 1'b0;
      end else if (c == csl_pkg::CH_SLASH) begin
         fr_mode  = csl_pkg::MODE_SLASH;
         fr_first = c;
      end else if (csl_pkg::is_alpha(c) || (c == csl_pkg::CH_UNDERSCORE)) begin
         fr_mode  = csl_pkg::MODE_IDENT;
         fr_first = c;
         fr_cands = csl_pkg::kw_narrow(csl_pkg::ALL_KW, 8'd0, c);
         fr_len   = 8'd1;
      end else if (csl_pkg::is_digit(c)) begin
         fr_mode  = csl_pkg::MODE_CONST;
         fr_first = c;
         fr_len   = 8'd1;
      end else begin
         fr_emit     = 1'b1;
         fr_tok.kind = csl_pkg::KIND_SYMBOL;
         fr_tok.line = line_ff;
         fr_tok.len  = 8'd1;
         fr_tok.sym  = c;
      end
   end

   always_comb begin
      match       = csl_pkg::kw_match(cands_ff, len_ff);
      fl_tok      = '0;
      fl_tok.kind = (mode_ff == csl_pkg::MODE_CONST) ? csl_pkg::KIND_CONST
                                                      : csl_pkg::KIND_IDENT;
      if ((mode_ff == csl_pkg::MODE_IDENT) && match.hit) begin
         fl_tok.kind = csl_pkg::KIND_KEYWORD;
         fl_tok.kwi  = match.idx;
      end
      fl_tok.line = line_ff;
      fl_tok.len  = len_ff;
      fl_tok.sym  = first_ff;

      slash_tok      = '0;
      slash_tok.kind = csl_pkg::KIND_SYMBOL;
      slash_tok.line = line_ff;
      slash_tok.len  = 8'd1;
      slash_tok.sym  = csl_pkg::CH_SLASH;

      cmt_tok      = '0;
      cmt_tok.kind = csl_pkg::KIND_COMMENT;
      cmt_tok.line = line_ff;
      cmt_tok.len  = len_ff;
      cmt_tok.sym  = csl_pkg::CH_SLASH;

      end_tok      = '0;
      end_tok.kind = csl_pkg::KIND_END;
      end_tok.line = line_ff;
   end

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      len_in   = len_ff;
      cands_in = cands_ff;
      first_in = first_ff;
      t0       = '0;
      t1       = '0;
      t0v      = 1'b0;
      t1v      = 1'b0;
      if (req.end_of_input) begin
         // flush what is pending, then close with the end token
         case (mode_ff)
            csl_pkg::MODE_IDENT, csl_pkg::MODE_CONST: begin
               t0  = fl_tok;
               t0v = 1'b1;
            end
            csl_pkg::MODE_SLASH: begin
               t0  = slash_tok;
               t0v = 1'b1;
            end
            csl_pkg::MODE_COMMENT: begin
               t0  = cmt_tok;
               t0v = 1'b1;
            end
            default: t0v = 1'b0;
         endcase
         if (t0v) begin
            t1  = end_tok;
            t1v = 1'b1;
         end else begin
            t0  = end_tok;
            t0v = 1'b1;
         end
         mode_in  = csl_pkg::MODE_IDLE;
         len_in   = 8'd0;
         cands_in = csl_pkg::ALL_KW;
      end else begin
         case (mode_ff)
            csl_pkg::MODE_IDENT, csl_pkg::MODE_CONST: begin
               if ((mode_ff == csl_pkg::MODE_IDENT) ? csl_pkg::is_idchar(c)
                                                    : csl_pkg::is_digit(c)) begin
                  if (mode_ff == csl_pkg::MODE_IDENT) begin
                     cands_in = csl_pkg::kw_narrow(cands_ff, len_ff, c);
                  end
                  len_in = len_bump;
               end else begin
                  t0       = fl_tok;
                  t0v      = 1'b1;
                  t1       = fr_tok;
                  t1v      = fr_emit;
                  mode_in  = fr_mode;
                  line_in  = fr_line;
                  len_in   = fr_len;
                  cands_in = fr_cands;
                  first_in = fr_first;
               end
            end
            csl_pkg::MODE_SLASH: begin
               if (c == csl_pkg::CH_SLASH) begin
                  // the comment owns its newline, so count the line now
                  mode_in = csl_pkg::MODE_COMMENT;
                  len_in  = 8'd2;
                  line_in = line_ff + 16'd1;
               end else begin
                  t0       = slash_tok;
                  t0v      = 1'b1;
                  t1       = fr_tok;
                  t1v      = fr_emit;
                  mode_in  = fr_mode;
                  line_in  = fr_line;
                  len_in   = fr_len;
                  cands_in = fr_cands;
                  first_in = fr_first;
               end
            end
            csl_pkg::MODE_COMMENT: begin
               if (c == csl_pkg::CH_NL) begin
                  t0       = cmt_tok;
                  t0v      = 1'b1;
                  mode_in  = csl_pkg::MODE_IDLE;
                  len_in   = 8'd0;
                  cands_in = csl_pkg::ALL_KW;
               end else begin
                  len_in = len_bump;
               end
            end
            default: begin
               t0       = fr_tok;
               t0v      = fr_emit;
               mode_in  = fr_mode;
               line_in  = fr_line;
               len_in   = fr_len;
               cands_in = fr_cands;
               first_in = fr_first;
            end
         endcase
      end
   end

   assign qpush.valid     = accept && t0v;
   assign qpush.data.two  = t1v;
   assign qpush.data.tok0 = t0;
   assign qpush.data.tok1 = t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= csl_pkg::MODE_IDLE;
         line_ff  <= 16'd1;
         len_ff   <= 8'd0;
         cands_ff <= csl_pkg::ALL_KW;
         first_ff <= 8'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         len_ff   <= len_in;
         cands_ff <= cands_in;
         first_ff <= first_in;
      end
   end

   `CSL_ASSERT_NXT(a_eoi_idle, accept && req.end_of_input, (mode_ff == csl_pkg::MODE_IDLE) && (len_ff == 8'd0), "end of input did not return to idle")
   `CSL_ASSERT_NXT(a_line_hold, !accept, $stable(line_ff), "line count moved without an accepted word")

endmodule

// ===== design/csl_queue.sv =====
`include "c_subset_lexer_top_assert.svh"

module csl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  csl_pkg::queue_push_type   qpush,
   input  logic                      pop,
   output csl_pkg::queue_status_type qstat,
   output csl_pkg::entry_type        head
);

   csl_pkg::entry_type            entry_ff [csl_pkg::QUEUE_DEPTH];
   logic [csl_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [csl_pkg::QPTR_W:0]      count_ff, count_in;
   logic                          do_push, do_pop;

   assign qstat.full  = (count_ff == (csl_pkg::QPTR_W+1)'(csl_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = qpush.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= qpush.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CSL_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= (csl_pkg::QPTR_W+1)'(csl_pkg::QUEUE_DEPTH), "queue count past depth")
   `CSL_ASSERT_IMP(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")

endmodule

// ===== design/csl_back.sv =====
`include "c_subset_lexer_top_assert.svh"

module csl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  csl_pkg::queue_status_type qstat,
   input  csl_pkg::entry_type        head,
   output logic                      pop,
   csl_rsp_if.source                 rsp
);

   logic               sel_ff, sel_in;
   logic               is_last;
   logic               fire;
   csl_pkg::token_type tok;

   assign tok     = sel_ff ? head.tok1 : head.tok0;
   assign is_last = !head.two || sel_ff;
   assign fire    = rsp.valid && rsp.ready;
   assign pop     = fire && is_last;

   assign rsp.valid         = !qstat.empty;
   assign rsp.token_kind    = tok.kind;
   assign rsp.line_number   = tok.line;
   assign rsp.lexeme_length = tok.len;
   assign rsp.keyword_index = tok.kwi;
   assign rsp.symbol_byte   = tok.sym;
   assign rsp.last          = is_last;

   // step to the second token of a pair, back to the first on pop
   always_comb begin
      sel_in = sel_ff;
      if (fire) begin
         sel_in = !is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   `CSL_ASSERT_IMP(a_sel_pair, sel_ff, head.two && !qstat.empty, "second token selected without a pair")

endmodule

// ===== design/c_subset_lexer_top.sv =====
// C-subset lexer: turns a byte stream into tokens.
// req_ch (sink): one word per source byte, in_byte plus end_of_input; a word
//   with end_of_input set flushes any pending token and adds an end token.
// rsp_ch (source): one word per token: kind, line number, length, keyword
//   index, symbol byte; last marks the final token caused by one input word.
// Both channels move a word on a rising clock edge with valid and ready high.
// Throughput: one input word per cycle while the queue has room. An input word
//   makes zero, one or two tokens; the output side moves one token per cycle
//   while the receiver is ready, so the two tokens of a word go out in turn.
// With nothing queued ahead, the first token of a word is offered on rsp_ch in
//   the cycle after the word is accepted; a second one follows once it is taken.
// A four-entry queue sits between the lexer front end and the output stage;
//   each entry holds all tokens of one input word. req_ch.ready drops only
//   when the queue is full, so a stalled receiver stops input after four
//   token-producing words, and no token is lost or repeated.
// Reset (synchronous, active high): scanner idle, line count one, queue empty.
module c_subset_lexer_top (
   input  logic      clock,
   input  logic      reset,
   csl_req_if.sink   req_ch,
   csl_rsp_if.source rsp_ch
);

   csl_pkg::queue_push_type   qpush;
   csl_pkg::queue_status_type qstat;
   csl_pkg::entry_type        head;
   logic                      pop;

   // front end: classify each byte, track scan state, build token words
   csl_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .qstat (qstat),
      .qpush (qpush)
   );

   // decoupling queue: hold token groups until the output side drains them
   csl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qpush (qpush),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   // back end: send each token of the head group, mark the last one
   csl_back u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   // one source word as it goes onto req_ch
   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } src_word_type;

   // one token as it is expected on rsp_ch
   typedef struct packed {
      csl_pkg::token_kind_type kind;
      logic [15:0]             line;
      logic [7:0]              len;
      logic [3:0]              kwi;
      logic [7:0]              sym;
      logic                    last;
   } lex_token_type;

   logic clock;
   logic reset;

   csl_req_if req_ch ();
   csl_rsp_if rsp_ch ();

   c_subset_lexer_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // keyword spellings in table order; the position is the keyword index
   string keywords [csl_pkg::NUM_KW] = '{"int", "float", "char", "if", "else", "while",
                                         "for", "return", "do"};

   src_word_type  words_pending [$];   // source words not yet accepted
   lex_token_type tokens_due [$];      // tokens predicted but not yet seen

   // scanner state kept by the predictor
   csl_pkg::scan_mode_type scan_state;
   logic [15:0]            line_ctr;
   logic [7:0]             run_len;
   logic [8:0]             kw_alive;
   logic [7:0]             lead_byte;

   bit word_taken;
   int cycle_no;
   int cycle_limit;
   int err_count;
   int words_sent;
   int eoi_sent;
   int tokens_seen;
   int kind_tally [7];

   // ---------------------------------------------------------------
   // character classes
   // ---------------------------------------------------------------
   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word_char(logic [7:0] c);
      return is_letter(c) || is_numeral(c) || c == csl_pkg::CH_UNDERSCORE;
   endfunction

   function automatic bit is_gap(logic [7:0] c);
      return c == csl_pkg::CH_SPACE || c == csl_pkg::CH_TAB || c == csl_pkg::CH_VT ||
             c == csl_pkg::CH_FF || c == csl_pkg::CH_CR;
   endfunction

   // ---------------------------------------------------------------
   // token predictor
   // ---------------------------------------------------------------

   // drop the keywords whose byte at pos differs from c
   function automatic logic [8:0] kw_keep(logic [8:0] alive, int pos, logic [7:0] c);
      logic [8:0] r;
      r = '0;
      for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
         if (alive[k] && pos < keywords[k].len() && keywords[k][pos] == c) begin
            r[k] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void add_token(csl_pkg::token_kind_type kind, logic [7:0] len,
                                     logic [3:0] kwi, logic [7:0] sym);
      lex_token_type t;
      t.kind = kind;
      t.line = line_ctr;
      t.len  = len;
      t.kwi  = kwi;
      t.sym  = sym;
      t.last = 1'b0;
      tokens_due.push_back(t);
   endfunction

   function automatic void go_idle();
      scan_state = csl_pkg::MODE_IDLE;
      run_len    = '0;
      kw_alive   = csl_pkg::ALL_KW;
   endfunction

   // emit the pending identifier, keyword or constant
   function automatic void close_word();
      csl_pkg::token_kind_type kind;
      logic [3:0]              kwi;
      kind = (scan_state == csl_pkg::MODE_CONST) ? csl_pkg::KIND_CONST
                                                 : csl_pkg::KIND_IDENT;
      kwi  = '0;
      if (scan_state == csl_pkg::MODE_IDENT) begin
         for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
            if (kw_alive[k] && keywords[k].len() == int'(run_len)) begin
               kind = csl_pkg::KIND_KEYWORD;
               kwi  = 4'(k);
            end
         end
      end
      add_token(kind, run_len, kwi, lead_byte);
   endfunction

   // lex c as the first byte of a new token
   function automatic void start_token(logic [7:0] c);
      go_idle();
      if (c == csl_pkg::CH_NL) begin
         line_ctr = line_ctr + 16'd1;
         add_token(csl_pkg::KIND_EMPTY, 8'd1, 4'd0, c);
      end else if (c == csl_pkg::CH_SLASH) begin
         scan_state = csl_pkg::MODE_SLASH;
         lead_byte  = c;
      end else if (is_letter(c) || c == csl_pkg::CH_UNDERSCORE) begin
         scan_state = csl_pkg::MODE_IDENT;
         lead_byte  = c;
         kw_alive   = kw_keep(csl_pkg::ALL_KW, 0, c);
         run_len    = 8'd1;
      end else if (is_numeral(c)) begin
         scan_state = csl_pkg::MODE_CONST;
         lead_byte  = c;
         run_len    = 8'd1;
      end else if (!is_gap(c)) begin
         add_token(csl_pkg::KIND_SYMBOL, 8'd1, 4'd0, c);
      end
   endfunction

   // advance the scanner by one accepted word and queue the tokens it causes
   function automatic void lex_word(src_word_type w);
      int            first_new;
      lex_token_type t;
      first_new = tokens_due.size();
      if (w.eoi) begin
         case (scan_state)
            csl_pkg::MODE_IDENT, csl_pkg::MODE_CONST: close_word();
            csl_pkg::MODE_SLASH:
               add_token(csl_pkg::KIND_SYMBOL, 8'd1, 4'd0, csl_pkg::CH_SLASH);
            csl_pkg::MODE_COMMENT:
               add_token(csl_pkg::KIND_COMMENT, run_len, 4'd0, csl_pkg::CH_SLASH);
            default: ;
         endcase
         go_idle();
         add_token(csl_pkg::KIND_END, 8'd0, 4'd0, 8'd0);
      end else if (scan_state == csl_pkg::MODE_IDENT || scan_state == csl_pkg::MODE_CONST) begin
         if (scan_state == csl_pkg::MODE_IDENT ? is_word_char(w.ch) : is_numeral(w.ch)) begin
            if (scan_state == csl_pkg::MODE_IDENT) begin
               kw_alive = kw_keep(kw_alive, int'(run_len), w.ch);
            end
            if (run_len < csl_pkg::MAX_LEXEME) begin
               run_len = run_len + 8'd1;
            end
         end else begin
            close_word();
            start_token(w.ch);
         end
      end else if (scan_state == csl_pkg::MODE_SLASH) begin
         if (w.ch == csl_pkg::CH_SLASH) begin
            // second slash opens a comment and takes the line count up front
            scan_state = csl_pkg::MODE_COMMENT;
            run_len    = 8'd2;
            line_ctr   = line_ctr + 16'd1;
         end else begin
            add_token(csl_pkg::KIND_SYMBOL, 8'd1, 4'd0, csl_pkg::CH_SLASH);
            start_token(w.ch);
         end
      end else if (scan_state == csl_pkg::MODE_COMMENT) begin
         if (w.ch == csl_pkg::CH_NL) begin
            add_token(csl_pkg::KIND_COMMENT, run_len, 4'd0, csl_pkg::CH_SLASH);
            go_idle();
         end else if (run_len < csl_pkg::MAX_LEXEME) begin
            run_len = run_len + 8'd1;
         end
      end else begin
         start_token(w.ch);
      end
      // mark the final token of this word
      if (tokens_due.size() > first_new) begin
         t      = tokens_due.pop_back();
         t.last = 1'b1;
         tokens_due.push_back(t);
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------
   function automatic void put_byte(logic [7:0] b);
      src_word_type w;
      w.ch  = b;
      w.eoi = 1'b0;
      words_pending.push_back(w);
   endfunction

   function automatic void put_eoi();
      src_word_type w;
      w.ch  = 8'($urandom_range(0, 255));   // ignored by the block, toggle it anyway
      w.eoi = 1'b1;
      words_pending.push_back(w);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         put_byte(s[i]);
      end
   endfunction

   function automatic logic [7:0] rand_word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) begin
         return "A" + 8'(r);
      end else if (r < 52) begin
         return "a" + 8'(r - 26);
      end else if (r < 62) begin
         return "0" + 8'(r - 52);
      end
      return csl_pkg::CH_UNDERSCORE;
   endfunction

   function automatic logic [7:0] rand_lead_char();
      logic [7:0] c;
      do begin
         c = rand_word_char();
      end while (is_numeral(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_body_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == csl_pkg::CH_NL);
      return c;
   endfunction

   function automatic logic [7:0] rand_gap();
      case ($urandom_range(0, 4))
         0:       return csl_pkg::CH_TAB;
         1:       return csl_pkg::CH_VT;
         2:       return csl_pkg::CH_FF;
         3:       return csl_pkg::CH_CR;
         default: return csl_pkg::CH_SPACE;
      endcase
   endfunction

   // one piece of mostly well-formed source text, with some noise
   function automatic void put_fragment();
      string kw;
      string punct;
      int    pick;
      int    n;
      punct = "(){};,=+-*<>!&|%";
      pick  = $urandom_range(0, 99);
      if (pick < 22) begin
         kw = keywords[$urandom_range(0, csl_pkg::NUM_KW - 1)];
         case ($urandom_range(0, 4))
            0:       put_text(kw.substr(0, kw.len() - 2));      // keyword prefix
            1: begin
               put_text(kw);
               put_byte(rand_word_char());                     // keyword run on
            end
            default: put_text(kw);
         endcase
      end else if (pick < 37) begin
         n = $urandom_range(1, 10);
         put_byte(rand_lead_char());
         for (int i = 1; i < n; i++) begin
            put_byte(rand_word_char());
         end
      end else if (pick < 50) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            put_byte("0" + 8'($urandom_range(0, 9)));
         end
      end else if (pick < 62) begin
         put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         put_byte(punct[$urandom_range(0, punct.len() - 1)]);
      end else if (pick < 80) begin
         put_text("//");
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i++) begin
            put_byte(rand_body_byte());
         end
         if ($urandom_range(0, 9) != 0) begin
            put_byte(csl_pkg::CH_NL);
         end
      end else if (pick < 86) begin
         put_byte(csl_pkg::CH_SLASH);
      end else if (pick < 96) begin
         put_byte(csl_pkg::CH_NL);
      end else if (pick < 98) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            put_byte(rand_gap());
         end
      end else begin
         put_eoi();
      end
      // half the time set a blank after this piece; otherwise the next one runs on
      if ($urandom_range(0, 1) == 0) begin
         put_byte(($urandom_range(0, 3) == 0) ? rand_gap() : csl_pkg::CH_SPACE);
      end
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------
   task automatic note_error(string what);
      err_count++;
      $display("tb_top: cycle %0d: %s", cycle_no, what);
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         note_error($sformatf("token %0d %s: got %0h, want %0h", tokens_seen, name, got,
                              want));
      end
   endtask

   // idle about 15 percent of the time, but never inside the calm stretch
   function automatic bit take_break();
      if (cycle_no >= 500 && cycle_no < 1100) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 15;
   endfunction

   // ---------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // driver: change inputs on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !take_break();
         // hold an offered word until it is taken; otherwise offer the next one or idle
         if (!req_ch.valid || word_taken) begin
            if (words_pending.size() != 0 && !take_break()) begin
               req_ch.valid        <= 1'b1;
               req_ch.in_byte      <= words_pending[0].ch;
               req_ch.end_of_input <= words_pending[0].eoi;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: sample both channels on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch
      lex_token_type want;
      cycle_no++;
      if (cycle_no > cycle_limit) begin
         $display("tb_top: no finish by cycle %0d, %0d words and %0d tokens left",
                  cycle_no, words_pending.size(), tokens_due.size());
         $display("tb_top NOT OK");
         $finish;
      end else if (reset) begin
         word_taken = 1'b0;
      end else begin
         // input side: an accepted word advances the predictor
         word_taken = req_ch.valid && req_ch.ready;
         if (word_taken) begin
            words_sent++;
            if (words_pending[0].eoi) begin
               eoi_sent++;
            end
            lex_word(words_pending.pop_front());
         end
         // output side: match each token with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            tokens_seen++;
            if (tokens_due.size() == 0) begin
               note_error($sformatf("token %0d kind %0d line %0d arrived with none due",
                                    tokens_seen, rsp_ch.token_kind, rsp_ch.line_number));
            end else begin
               want = tokens_due.pop_front();
               kind_tally[int'(want.kind)]++;
               check_field("kind", 16'(rsp_ch.token_kind), 16'(want.kind));
               check_field("line", rsp_ch.line_number, want.line);
               check_field("length", 16'(rsp_ch.lexeme_length), 16'(want.len));
               check_field("keyword index", 16'(rsp_ch.keyword_index), 16'(want.kwi));
               check_field("symbol byte", 16'(rsp_ch.symbol_byte), 16'(want.sym));
               check_field("last", 16'(rsp_ch.last), 16'(want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int n;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.in_byte      = 8'd0;
      req_ch.end_of_input = 1'b0;
      rsp_ch.ready        = 1'b0;
      word_taken          = 1'b0;
      cycle_no            = 0;
      err_count           = 0;
      words_sent          = 0;
      eoi_sent            = 0;
      tokens_seen         = 0;
      foreach (kind_tally[k]) begin
         kind_tally[k] = 0;
      end
      go_idle();
      line_ctr  = 16'd1;
      lead_byte = 8'd0;

      // directed part: keyword, identifier ended by a symbol, constant ended by a
      // newline, lone slash before a letter, end mark on a pending identifier and on
      // a pending slash, comment with a high byte, end mark inside an open comment,
      // then the zero byte, a high byte and a skipped tab
      put_text("do _Z9+90\n/x");
      put_eoi();
      put_byte(csl_pkg::CH_SLASH);
      put_eoi();
      put_text("//");
      put_byte(8'hFF);
      put_byte(csl_pkg::CH_NL);
      put_text("//");
      put_eoi();
      put_byte(8'h00);
      put_byte(8'h80);
      put_byte(csl_pkg::CH_TAB);

      // over-long lexemes: the reported length saturates
      n = $urandom_range(255, 300);
      put_byte(rand_lead_char());
      for (int i = 1; i < n; i++) begin
         put_byte(rand_word_char());
      end
      put_byte(";");
      n = $urandom_range(250, 270);
      for (int i = 0; i < n; i++) begin
         put_byte("0" + 8'($urandom_range(0, 9)));
      end
      put_byte(csl_pkg::CH_SPACE);
      n = $urandom_range(253, 300);
      put_text("//");
      for (int i = 2; i < n; i++) begin
         put_byte(rand_body_byte());
      end
      put_byte(csl_pkg::CH_NL);

      // random source text up to the word budget
      while (words_pending.size() < 1500) begin
         put_fragment();
      end
      put_eoi();

      // allow every word two tokens, each held up by stalls on both sides
      cycle_limit = 20 * words_pending.size() + 20000;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for all words to go in and all predicted tokens to come out
      while (words_pending.size() != 0) begin
         @(posedge clock);
      end
      while (tokens_due.size() != 0) begin
         @(posedge clock);
      end
      // linger a little so a stray extra token is still caught
      repeat (20) @(posedge clock);

      $display("tb_top: %0d source words sent (%0d end marks), %0d tokens checked",
               words_sent, eoi_sent, tokens_seen);
      $display("tb_top: keyword %0d, ident %0d, const %0d, symbol %0d, end %0d, %s %0d, %s %0d",
               kind_tally[csl_pkg::KIND_KEYWORD], kind_tally[csl_pkg::KIND_IDENT],
               kind_tally[csl_pkg::KIND_CONST], kind_tally[csl_pkg::KIND_SYMBOL],
               kind_tally[csl_pkg::KIND_END], "empty line",
               kind_tally[csl_pkg::KIND_EMPTY], "comment", kind_tally[csl_pkg::KIND_COMMENT]);
      if (err_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
